FILE: src/png_unf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PNG unfilter package
// Shared widths, limits, register indexes and filter codes of the scanline
// unfilter core.
// ----------------------------------------------------------------------------
package png_unf_pkg;

  localparam int unsigned MAX_ROW_BYTES   = 16384;
  localparam int unsigned MAX_PIXEL_BYTES = 8;

  localparam int unsigned COL_W  = $clog2(MAX_ROW_BYTES);
  localparam int unsigned ROW_W  = 15;
  localparam int unsigned BPP_W  = 4;
  localparam int unsigned HIST_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_W  = ROW_W;

  localparam logic [ROW_W-1:0] ROW_BYTES_RESET = ROW_W'(1024);
  localparam logic [BPP_W-1:0] BPP_RESET       = BPP_W'(4);
  localparam logic [ROW_W-1:0] ROW_BYTES_MAX   = ROW_W'(MAX_ROW_BYTES);
  localparam logic [BPP_W-1:0] BPP_MAX         = BPP_W'(MAX_PIXEL_BYTES);

  typedef enum logic [0:0] {
    REG_ROW_BYTES    = 1'b0,
    REG_PIXEL_STRIDE = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_e;

endpackage
`default_nettype wire

FILE: src/png_scanline_unfilter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PNG scanline unfilter core
// Rebuilds PNG image bytes from filtered scanline bytes (None, Sub, Up,
// Average, Paeth), one byte per item.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream takes one filtered byte per item, with the frame start
// flag and the row filter code in tuser. The filter code is sampled on the
// first byte of each row. The master stream returns one reconstructed byte
// per item, tlast on the last byte of a row and tuser set for a bad filter.
// The configuration channel writes row_bytes (index 0) and the pixel stride
// (index 1); it is always ready. The user must write it only while the core
// is idle; the core does not enforce this. An item passes the store stage
// and the output register. One item is accepted per cycle unless the receiver
// stalls; the line store is read at acceptance and written as the item leaves
// the store stage, a forwarding register covering a read of the entry written.
// Reset clears the column, the histories and the registers at once; the line
// store needs no clearing, since the first row of a frame never reads it.
// When the receiver stalls, the output register and one item in the store
// stage hold, and the slave side stops accepting after that.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_core
  import png_unf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Slave stream.
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [7:0]        s_axis_tdata_i,   // [7:0] filtered_byte
  input  wire logic [3:0]        s_axis_tuser_i,   // [0] frame_start, [3:1] filter_type
  // Master stream.
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic      [7:0]        m_axis_tdata_o,   // [7:0] pixel_byte
  output logic                   m_axis_tlast_o,   // row_done
  output logic      [0:0]        m_axis_tuser_o,   // [0] bad_filter
  // Configuration write channel.
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [0:0]        cfg_index_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i
);

  logic [ROW_W-1:0]  row_bytes_q;
  logic [BPP_W-1:0]  bpp_q;
  logic [ROW_W-1:0]  rb_eff;
  logic [HIST_W-1:0] bpp_idx;
  logic [BPP_W-1:0]  bpp_eff;

  logic [COL_W-1:0]  col_q, col_d;
  logic [2:0]        held_q, held_d;
  logic              first_row_q, first_row_d;

  logic              in_acc;
  logic [COL_W-1:0]  col_eff;
  logic              first_row_eff;
  logic [2:0]        filt_eff;
  logic              done_eff;

  logic              s1_valid_q;
  logic [COL_W-1:0]  s1_col_q;
  logic [2:0]        s1_filt_q;
  logic              s1_first_row_q;
  logic              s1_first_pix_q;
  logic              s1_done_q;
  logic [BYTE_W-1:0] s1_byte_q;
  logic              s1_adv;

  logic              fwd_q;
  logic [BYTE_W-1:0] fwd_data_q;
  logic [BYTE_W-1:0] ram_rdata;

  logic [BYTE_W-1:0] left_hist_q [MAX_PIXEL_BYTES];
  logic [BYTE_W-1:0] ul_hist_q   [MAX_PIXEL_BYTES];

  logic [BYTE_W-1:0] above, left, upl, pred, res;
  logic              bad;
  logic signed [9:0] pa, pb, pc, aa, ab, ac;
  logic [BYTE_W:0]   avg_sum;
  logic [BYTE_W-1:0] paeth_pred;

  // Configuration registers, clamped into range.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q <= ROW_BYTES_RESET;
      bpp_q       <= BPP_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ROW_BYTES:    row_bytes_q <= cfg_data_i;
        REG_PIXEL_STRIDE: bpp_q       <= cfg_data_i[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (row_bytes_q == '0) begin
      rb_eff = ROW_W'(1);
    end else if (row_bytes_q > ROW_BYTES_MAX) begin
      rb_eff = ROW_BYTES_MAX;
    end else begin
      rb_eff = row_bytes_q;
    end
    priority if (bpp_q == '0) begin
      bpp_eff = BPP_W'(1);
    end else if (bpp_q > BPP_MAX) begin
      bpp_eff = BPP_MAX;
    end else begin
      bpp_eff = bpp_q;
    end
    bpp_idx = HIST_W'(bpp_eff - BPP_W'(1));
  end

  // Row and column tracking at acceptance.
  assign s1_adv          = s1_valid_q && (!m_axis_tvalid_o || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    col_eff       = s_axis_tuser_i[0] ? '0 : col_q;
    first_row_eff = s_axis_tuser_i[0] || first_row_q;
    filt_eff      = (col_eff == '0) ? s_axis_tuser_i[3:1] : held_q;
    done_eff      = ({1'b0, col_eff} + ROW_W'(1)) >= rb_eff;
    col_d         = col_q;
    held_d        = held_q;
    first_row_d   = first_row_q;
    if (in_acc) begin
      held_d      = filt_eff;
      col_d       = done_eff ? '0 : col_eff + COL_W'(1);
      first_row_d = done_eff ? 1'b0 : first_row_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      held_q      <= '0;
      first_row_q <= 1'b1;
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      col_q       <= col_d;
      held_q      <= held_d;
      first_row_q <= first_row_d;
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_adv && (s1_col_q == col_eff);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
        fwd_q      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q       <= col_eff;
      s1_filt_q      <= filt_eff;
      s1_first_row_q <= first_row_eff;
      s1_first_pix_q <= col_eff < COL_W'(bpp_eff);
      s1_done_q      <= done_eff;
      s1_byte_q      <= s_axis_tdata_i;
      fwd_data_q     <= res;
    end
  end

  // Line store holding the previous reconstructed row.
  png_unf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_ROW_BYTES)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (res),
    .re_i    (in_acc),
    .raddr_i (col_eff),
    .rdata_o (ram_rdata)
  );

  // Reconstruction.
  always_comb begin
    above   = s1_first_row_q ? '0 : (fwd_q ? fwd_data_q : ram_rdata);
    left    = s1_first_pix_q ? '0 : left_hist_q[bpp_idx];
    upl     = (s1_first_pix_q || s1_first_row_q) ? '0 : ul_hist_q[bpp_idx];
    avg_sum = {1'b0, left} + {1'b0, above};
    pa      = $signed({2'b00, above}) - $signed({2'b00, upl});
    pb      = $signed({2'b00, left}) - $signed({2'b00, upl});
    pc      = pa + pb;
    aa      = (pa < 0) ? -pa : pa;
    ab      = (pb < 0) ? -pb : pb;
    ac      = (pc < 0) ? -pc : pc;
    priority if (aa <= ab && aa <= ac) begin
      paeth_pred = left;
    end else if (ab <= ac) begin
      paeth_pred = above;
    end else begin
      paeth_pred = upl;
    end
    bad = 1'b0;
    unique case (s1_filt_q)
      FILT_NONE:  pred = '0;
      FILT_SUB:   pred = left;
      FILT_UP:    pred = above;
      FILT_AVG:   pred = avg_sum[BYTE_W:1];
      FILT_PAETH: pred = paeth_pred;
      default: begin
        pred = '0;
        bad  = 1'b1;
      end
    endcase
    res = s1_byte_q + pred;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_hist_q[i] <= '0;
        ul_hist_q[i]   <= '0;
      end
    end else if (s1_adv) begin
      left_hist_q[0] <= res;
      ul_hist_q[0]   <= above;
      for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
        left_hist_q[i] <= left_hist_q[i-1];
        ul_hist_q[i]   <= ul_hist_q[i-1];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid_o <= 1'b0;
    end else if (s1_adv) begin
      m_axis_tvalid_o <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_axis_tvalid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      m_axis_tdata_o <= res;
      m_axis_tlast_o <= s1_done_q;
      m_axis_tuser_o <= bad;
    end
  end

  // Checks.
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> s_axis_tready_o)
    else $error("input not ready while the store stage is empty");

  a_fwd_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_valid_q)
    else $error("forwarding flag set without an item in the store stage");

  a_done_wraps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && done_eff) |=> (col_q == '0 && !first_row_q))
    else $error("column did not wrap at the end of a row");

  a_stage_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !m_axis_tvalid_o) |-> s1_adv)
    else $error("store stage held while the output register is empty");

endmodule
`default_nettype wire

FILE: src/png_unf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered and
// returns the old contents on a same-address write.
// ----------------------------------------------------------------------------
module png_unf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: tb/png_scanline_unfilter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter core testbench
// Sends filtered scanline bytes through the slave stream and checks every
// reconstructed byte, row end flag and bad filter flag on the master stream
// against a line-store predictor of None, Sub, Up, Average and Paeth
// reconstruction. The tests cover each filter code, register extremes, a row
// length lowered mid-row, a long receiver stall, an oversized row length
// setting and random frames under random idling on both sides.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_core_tb;
  import png_unf_pkg::*;

  localparam logic [2:0] FILT_RSVD5 = 3'd5;
  localparam logic [2:0] FILT_RSVD6 = 3'd6;
  localparam logic [2:0] FILT_RSVD7 = 3'd7;

  typedef struct {
    logic [7:0] pixel;
    logic       row_end;
    logic       bad;
  } pixel_t;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  logic [7:0]       s_axis_tdata_i;
  logic [3:0]       s_axis_tuser_i;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i;
  logic [7:0]       m_axis_tdata_o;
  logic             m_axis_tlast_o;
  logic [0:0]       m_axis_tuser_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [0:0]       cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;

  // Predictor state.
  logic [ROW_W-1:0] row_cfg;
  logic [BPP_W-1:0] pix_cfg;
  logic [7:0]       line_mem     [MAX_ROW_BYTES];
  bit               line_written [MAX_ROW_BYTES];
  logic [7:0]       left_bytes   [8];
  logic [7:0]       upleft_bytes [8];
  int unsigned      col_q;
  logic [2:0]       held_q;
  bit               on_first_row;

  pixel_t      pixel_q[$];
  int unsigned fault_count;
  int unsigned sent_count;
  bit          steady;
  bit          offering;
  int unsigned hold_req;

  png_scanline_unfilter_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    int da;
    int db;
    int dc;
    da = int'(b) - int'(c);
    db = int'(a) - int'(c);
    dc = da + db;
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  task automatic unfilter_byte(input logic fs, input logic [2:0] ft, input logic [7:0] fb);
    int unsigned rl;
    int unsigned pw;
    logic [7:0]  up;
    logic [7:0]  lf;
    logic [7:0]  ul;
    logic [7:0]  pred;
    bit          lead;
    pixel_t      res;
    rl = (row_cfg == 0) ? 1 : ((row_cfg > MAX_ROW_BYTES) ? MAX_ROW_BYTES : row_cfg);
    pw = (pix_cfg == 0) ? 1 : ((pix_cfg > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : pix_cfg);
    if (fs) begin
      col_q = 0;
      on_first_row = 1'b1;
    end
    if (col_q == 0) held_q = ft;
    up = (on_first_row || col_q >= MAX_ROW_BYTES) ? 8'h00 : line_mem[col_q];
    lead = col_q < pw;
    lf = lead ? 8'h00 : left_bytes[pw-1];
    ul = (lead || on_first_row) ? 8'h00 : upleft_bytes[pw-1];
    res.bad = 1'b0;
    case (held_q)
      FILT_NONE:  pred = 8'h00;
      FILT_SUB:   pred = lf;
      FILT_UP:    pred = up;
      FILT_AVG:   pred = 8'((9'(lf) + 9'(up)) >> 1);
      FILT_PAETH: pred = paeth_pick(lf, up, ul);
      default: begin
        pred = 8'h00;
        res.bad = 1'b1;
      end
    endcase
    res.pixel = fb + pred;
    if (col_q < MAX_ROW_BYTES) begin
      line_mem[col_q] = res.pixel;
      line_written[col_q] = 1'b1;
    end
    for (int k = 7; k > 0; k--) begin
      left_bytes[k] = left_bytes[k-1];
      upleft_bytes[k] = upleft_bytes[k-1];
    end
    left_bytes[0] = res.pixel;
    upleft_bytes[0] = up;
    res.row_end = (col_q + 1 >= rl);
    if (res.row_end) begin
      col_q = 0;
      on_first_row = 1'b0;
    end else begin
      col_q++;
    end
    pixel_q.push_back(res);
  endtask

  task automatic send_item(input logic fs, input logic [2:0] ft, input logic [7:0] fb);
    while (!steady && $urandom_range(99) < 29) begin
      if (offering) begin
        s_axis_tvalid_i <= 1'b0;
        offering = 1'b0;
      end
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    offering = 1'b1;
    s_axis_tdata_i <= fb;
    s_axis_tuser_i <= {ft, fs};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    unfilter_byte(fs, ft, fb);
    sent_count++;
  endtask

  task automatic drain_pixels();
    if (offering) begin
      s_axis_tvalid_i <= 1'b0;
      offering = 1'b0;
    end
    while (pixel_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    drain_pixels();
    repeat (3) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_ROW_BYTES) row_cfg = val;
    else pix_cfg = val[BPP_W-1:0];
  endtask

  // A new frame is forced whenever the next byte would read a line store
  // entry that no earlier row has written.
  task automatic stream_bytes(input int unsigned count, input bit new_frame,
                              input int unsigned noise_pct);
    logic       fs;
    logic [2:0] ft;
    logic [7:0] fb;
    for (int unsigned i = 0; i < count; i++) begin
      fs = (i == 0 && new_frame) || ($urandom_range(99) < noise_pct);
      if (!fs && !on_first_row && col_q < MAX_ROW_BYTES && !line_written[col_q]) fs = 1'b1;
      if (fs || col_q == 0) begin
        ft = ($urandom_range(99) < 8) ? 3'($urandom_range(FILT_RSVD7, FILT_RSVD5))
                                      : 3'($urandom_range(FILT_PAETH, FILT_NONE));
      end else begin
        ft = 3'($urandom_range(7));
      end
      case ($urandom_range(9))
        0: fb = 8'h00;
        1: fb = 8'hFF;
        default: fb = 8'($urandom);
      endcase
      send_item(fs, ft, fb);
    end
  endtask

  task automatic test_directed_filters();
    write_reg(REG_ROW_BYTES, 15'd3);
    write_reg(REG_PIXEL_STRIDE, 15'd1);
    send_item(1'b1, FILT_NONE, 8'h00);
    send_item(1'b0, FILT_RSVD7, 8'hFF);
    send_item(1'b0, FILT_NONE, 8'h80);
    send_item(1'b0, FILT_SUB, 8'hFF);
    send_item(1'b0, FILT_RSVD5, 8'h01);
    send_item(1'b0, FILT_NONE, 8'h7F);
    send_item(1'b0, FILT_UP, 8'h01);
    send_item(1'b0, FILT_PAETH, 8'hFF);
    send_item(1'b0, FILT_SUB, 8'h00);
    send_item(1'b0, FILT_AVG, 8'hFF);
    send_item(1'b0, FILT_UP, 8'hFF);
    send_item(1'b0, FILT_RSVD6, 8'h01);
    send_item(1'b0, FILT_PAETH, 8'h80);
    send_item(1'b0, FILT_NONE, 8'h7F);
    send_item(1'b0, FILT_AVG, 8'hFF);
    send_item(1'b0, FILT_RSVD5, 8'h12);
    send_item(1'b0, FILT_SUB, 8'h34);
    send_item(1'b0, FILT_PAETH, 8'h56);
    send_item(1'b0, FILT_RSVD7, 8'hAB);
    send_item(1'b1, FILT_PAETH, 8'h55);
    send_item(1'b0, FILT_RSVD6, 8'hAA);
    send_item(1'b0, FILT_UP, 8'h0F);
    send_item(1'b0, FILT_RSVD6, 8'hFE);
    drain_pixels();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_ROW_BYTES, 15'd0);
    write_reg(REG_PIXEL_STRIDE, 15'd0);
    stream_bytes(12, 1'b1, 0);
    write_reg(REG_ROW_BYTES, 15'd2);
    write_reg(REG_PIXEL_STRIDE, 15'd15);
    stream_bytes(20, 1'b1, 0);
    write_reg(REG_ROW_BYTES, 15'(MAX_ROW_BYTES));
    write_reg(REG_PIXEL_STRIDE, 15'(MAX_PIXEL_BYTES));
    stream_bytes(40, 1'b1, 0);
    write_reg(REG_ROW_BYTES, 15'd1);
    stream_bytes(10, 1'b1, 0);
    drain_pixels();
  endtask

  task automatic test_row_shrink();
    write_reg(REG_ROW_BYTES, 15'd20);
    write_reg(REG_PIXEL_STRIDE, 15'd3);
    stream_bytes(32, 1'b1, 0);
    write_reg(REG_ROW_BYTES, 15'd8);
    stream_bytes(19, 1'b0, 0);
    write_reg(REG_ROW_BYTES, 15'd6);
    stream_bytes(15, 1'b0, 0);
    drain_pixels();
  endtask

  task automatic test_backpressure();
    write_reg(REG_ROW_BYTES, 15'd16);
    write_reg(REG_PIXEL_STRIDE, 15'd3);
    steady = 1'b1;
    hold_req = 300;
    stream_bytes(120, 1'b1, 0);
    drain_pixels();
    steady = 1'b0;
  endtask

  task automatic test_max_row();
    write_reg(REG_ROW_BYTES, 15'h7FFF);
    write_reg(REG_PIXEL_STRIDE, 15'd8);
    stream_bytes(300, 1'b1, 0);
    drain_pixels();
  endtask

  task automatic test_random();
    int unsigned target;
    logic [CFG_W-1:0] rb;
    target = sent_count + 1300;
    while (sent_count < target) begin
      case ($urandom_range(9))
        0: rb = 15'($urandom_range(2));
        1, 2: rb = 15'($urandom_range(300, 25));
        default: rb = 15'($urandom_range(24, 1));
      endcase
      if ($urandom_range(3) != 0) write_reg(REG_ROW_BYTES, rb);
      if ($urandom_range(3) != 0) begin
        write_reg(REG_PIXEL_STRIDE, ($urandom_range(9) == 0) ? 15'($urandom_range(15))
                                                              : 15'($urandom_range(8, 1)));
      end
      steady = ($urandom_range(9) == 0);
      stream_bytes($urandom_range(150, 20), $urandom_range(3) != 0, 2);
      drain_pixels();
    end
    steady = 1'b0;
  endtask

  // Receiver: random ready, with long holds on request.
  always @(posedge clk_i) begin
    int unsigned hold_left;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left--;
    end else if (steady) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= 29);
    end
  end

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pixel_q.size() == 0) begin
        fault_count++;
        if (fault_count < 40)
          $display("%0t: unexpected output item, pixel_byte %h", $time, m_axis_tdata_o);
      end else begin
        want = pixel_q.pop_front();
        if (m_axis_tdata_o !== want.pixel) begin
          fault_count++;
          if (fault_count < 40)
            $display("%0t: pixel_byte expected %h actual %h", $time, want.pixel,
                     m_axis_tdata_o);
        end
        if (m_axis_tlast_o !== want.row_end) begin
          fault_count++;
          if (fault_count < 40)
            $display("%0t: row_done expected %b actual %b", $time, want.row_end,
                     m_axis_tlast_o);
        end
        if (m_axis_tuser_o[0] !== want.bad) begin
          fault_count++;
          if (fault_count < 40)
            $display("%0t: bad_filter expected %b actual %b", $time, want.bad,
                     m_axis_tuser_o[0]);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("png_scanline_unfilter_core: mismatch");
    $finish;
  end

  initial begin
    row_cfg = ROW_BYTES_RESET;
    pix_cfg = BPP_RESET;
    for (int k = 0; k < 8; k++) begin
      left_bytes[k] = 8'h00;
      upleft_bytes[k] = 8'h00;
    end
    col_q = 0;
    held_q = FILT_NONE;
    on_first_row = 1'b1;
    fault_count = 0;
    sent_count = 0;
    steady = 1'b0;
    offering = 1'b0;
    hold_req = 0;
    rst_ni <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i <= 8'h00;
    s_axis_tuser_i <= 4'h0;
    m_axis_tready_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_ROW_BYTES;
    cfg_data_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_filters();
    test_register_extremes();
    test_row_shrink();
    test_backpressure();
    test_max_row();
    test_random();
    drain_pixels();
    repeat (10) @(posedge clk_i);
    if (fault_count == 0 && pixel_q.size() == 0) begin
      $display("png_scanline_unfilter_core: match");
    end else begin
      $display("png_scanline_unfilter_core: mismatch");
    end
    $finish;
  end

endmodule
